@@ rtl/core/mrs_pkg.sv @@
// Shared types, codes and helpers for the motor reversal sequencer.
package mrs_pkg;

  // Width of the measured motor speed field.
  localparam int unsigned SPEED_BITS = 12;

  // Width of the counters and configuration registers.
  localparam int unsigned CNT_BITS = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_STOP_WAIT  = 2'd0;
  localparam logic [1:0] REG_FAST_BLINK = 2'd1;
  localparam logic [1:0] REG_SLOW_BLINK = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CNT_BITS-1:0] STOP_WAIT_RESET  = 16'd3000;
  localparam logic [CNT_BITS-1:0] FAST_BLINK_RESET = 16'd100;
  localparam logic [CNT_BITS-1:0] SLOW_BLINK_RESET = 16'd1000;

  // Direction command codes.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  // Mode codes as reported on the result channel.
  localparam logic [2:0] MODE_CODE_STOP   = 3'd0;
  localparam logic [2:0] MODE_CODE_FWD    = 3'd1;
  localparam logic [2:0] MODE_CODE_BWD    = 3'd2;
  localparam logic [2:0] MODE_CODE_TO_BWD = 3'd3;
  localparam logic [2:0] MODE_CODE_TO_FWD = 3'd4;

  // Internal one-hot mode register encoding.
  typedef enum logic [4:0] {
    MODE_STOP   = 5'b00001,
    MODE_FWD    = 5'b00010,
    MODE_BWD    = 5'b00100,
    MODE_TO_BWD = 5'b01000,
    MODE_TO_FWD = 5'b10000
  } mode_t;

  // One tick item.
  typedef struct packed {
    logic                  forward_pressed;
    logic                  backward_pressed;
    logic                  stop_pressed;
    logic [SPEED_BITS-1:0] motor_speed;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] direction_cmd;
    logic       led_on;
    logic [2:0] mode_now;
  } out_item_t;

  // Configuration register set.
  typedef struct packed {
    logic [CNT_BITS-1:0] stop_wait_ms;
    logic [CNT_BITS-1:0] fast_blink_ms;
    logic [CNT_BITS-1:0] slow_blink_ms;
  } cfg_t;

  // Sequencer state carried from tick to tick.
  typedef struct packed {
    mode_t               mode;
    logic                wait_started;
    logic [CNT_BITS-1:0] wait_elapsed;
    logic [CNT_BITS-1:0] since_toggle;
    logic                led_level;
  } seq_state_t;

  // Increment that holds at the all-ones value.
  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    sat_inc = (v == {CNT_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Reported code of a one-hot mode.
  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] code;
    unique case (m)
      MODE_FWD:    code = MODE_CODE_FWD;
      MODE_BWD:    code = MODE_CODE_BWD;
      MODE_TO_BWD: code = MODE_CODE_TO_BWD;
      MODE_TO_FWD: code = MODE_CODE_TO_FWD;
      default:     code = MODE_CODE_STOP;
    endcase
    mode_code = code;
  endfunction

endpackage

@@ rtl/core/mrs_step.sv @@
// Next-state and result logic for one tick of the sequencer.
module mrs_step (
  input  mrs_pkg::seq_state_t state,
  input  mrs_pkg::cfg_t       cfg,
  input  mrs_pkg::in_item_t   item,
  output mrs_pkg::seq_state_t state_next,
  output mrs_pkg::out_item_t  result
);
  import mrs_pkg::*;

  logic                blink_en;
  logic [CNT_BITS-1:0] blink_period;
  logic                speed_zero;

  assign speed_zero = (item.motor_speed == '0);

  // Counters advance first, then the mode logic makes at most one transition.
  always_comb begin
    state_next = state;
    blink_en = 1'b0;
    blink_period = cfg.fast_blink_ms;
    state_next.since_toggle = sat_inc(state.since_toggle);
    if (state.wait_started) begin
      state_next.wait_elapsed = sat_inc(state.wait_elapsed);
    end

    unique case (state.mode)
      MODE_FWD: begin
        if (item.stop_pressed) begin
          state_next.mode = MODE_STOP;
        end else if (item.backward_pressed) begin
          state_next.mode = MODE_TO_BWD;
          state_next.wait_started = 1'b0;
        end
      end
      MODE_BWD: begin
        if (item.stop_pressed) begin
          state_next.mode = MODE_STOP;
        end else if (item.forward_pressed) begin
          state_next.mode = MODE_TO_FWD;
          state_next.wait_started = 1'b0;
        end
      end
      MODE_TO_BWD, MODE_TO_FWD: begin
        if (item.stop_pressed) begin
          state_next.mode = MODE_STOP;
          state_next.led_level = 1'b0;
        end else if (!speed_zero) begin
          blink_en = 1'b1;
          blink_period = cfg.fast_blink_ms;
        end else if (!state.wait_started) begin
          state_next.wait_started = 1'b1;
          state_next.wait_elapsed = '0;
        end else if (state_next.wait_elapsed < cfg.stop_wait_ms) begin
          blink_en = 1'b1;
          blink_period = cfg.slow_blink_ms;
        end else begin
          state_next.mode = (state.mode == MODE_TO_FWD) ? MODE_FWD : MODE_BWD;
          state_next.led_level = 1'b0;
        end
      end
      default: begin
        if (item.forward_pressed) begin
          state_next.mode = MODE_FWD;
        end else if (item.backward_pressed) begin
          state_next.mode = MODE_BWD;
        end else begin
          state_next.mode = MODE_STOP;
        end
      end
    endcase

    // Toggle the LED once the selected period has run out.
    if (blink_en && (state_next.since_toggle >= blink_period)) begin
      state_next.led_level = !state.led_level;
      state_next.since_toggle = '0;
    end
  end

  // Result fields follow the updated state.
  always_comb begin
    result.mode_now = mode_code(state_next.mode);
    result.led_on = state_next.led_level;
    if (state_next.mode == MODE_FWD) begin
      result.direction_cmd = DIR_FWD;
    end else if (state_next.mode == MODE_BWD) begin
      result.direction_cmd = DIR_BWD;
    end else begin
      result.direction_cmd = DIR_NONE;
    end
  end

endmodule

@@ rtl/core/motor_reversal_sequencer.sv @@
// Top level of the motor reversal sequencer: input register, state and result register.
//
// Each input transfer is one millisecond tick with the button states and the measured
// motor speed; each tick yields exactly one result with the direction command, the LED
// level and the current mode. The block takes one tick per clock cycle when the result
// side keeps up: a tick is held in the input register, and the combinational next-state
// logic then updates the mode, counters and LED and loads the result register, marking it
// valid, once that register is free or being emptied. A new tick is accepted while a
// finished result still waits, as long as the input register can move on. The user must
// write the three timing registers (standstill wait, fast and slow blink period) through
// the configuration port only while no tick is in flight; the block itself does not
// enforce this. Writes to an index past the third register are ignored.
module motor_reversal_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mrs_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import mrs_pkg::*;

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  in_item_t   in_item;
  logic       in_full;
  out_item_t  result;
  logic       advance;

  // The held tick moves on whenever the result register is free or being emptied.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_wait_ms  <= STOP_WAIT_RESET;
      cfg.fast_blink_ms <= FAST_BLINK_RESET;
      cfg.slow_blink_ms <= SLOW_BLINK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STOP_WAIT:  cfg.stop_wait_ms  <= cfg_data;
        REG_FAST_BLINK: cfg.fast_blink_ms <= cfg_data;
        REG_SLOW_BLINK: cfg.slow_blink_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick step logic.
  mrs_step u_step (
    .state      (state),
    .cfg        (cfg),
    .item       (in_item),
    .state_next (state_next),
    .result     (result)
  );

  // Pipeline control and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      out_valid <= 1'b0;
      state.mode <= MODE_STOP;
      state.wait_started <= 1'b0;
      state.wait_elapsed <= '0;
      state.since_toggle <= '0;
      state.led_level <= 1'b0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  // The direction command is forward exactly when the reported mode is forward.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.direction_cmd == DIR_FWD) == (out_data.mode_now == MODE_CODE_FWD)))
    else $error("direction command disagrees with reported mode");

  // The LED is dark in every mode other than stopping.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.mode_now != MODE_CODE_TO_BWD)
      && (out_data.mode_now != MODE_CODE_TO_FWD)) |-> !out_data.led_on)
    else $error("LED lit outside a stopping mode");

  // A rising LED always comes from a toggle, which restarts the blink counter.
  assert property (@(posedge clk) disable iff (rst)
    $rose(state.led_level) |-> (state.since_toggle == '0))
    else $error("LED turned on without restarting the blink counter");

  // A held tick stays in the input register while the result register is blocked.
  assert property (@(posedge clk) disable iff (rst)
    (in_full && out_valid && !out_ready) |=> in_full && $stable(state))
    else $error("tick lost or state changed while the result was stalled");

endmodule
